FILE: rtl/sctk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sctk_pkg;

    // Prefix bytes of scancode set 1.
    localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
    localparam logic [7:0] SC_PREFIX_E1 = 8'hE1;

    // Make codes with a fixed role (bit 7 stripped).
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_NUM    = 7'h45;
    localparam logic [6:0] KEY_SCROLL = 7'h46;
    localparam logic [6:0] KEY_ENTER  = 7'h1C;
    localparam logic [6:0] KEY_SLASH  = 7'h35;
    localparam logic [6:0] ROM_TOP    = 7'h58;
    localparam logic [6:0] KP_FIRST   = 7'h47;
    localparam logic [6:0] KP_LAST    = 7'h53;

    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_SLASH = 8'h2F;

    // Bit positions inside the modifier and lock flags.
    localparam int FLAG_RSHIFT = 0;
    localparam int FLAG_LSHIFT = 1;
    localparam int FLAG_CTRL   = 2;
    localparam int FLAG_ALT    = 3;
    localparam int FLAG_SCROLL = 4;
    localparam int FLAG_NUM    = 5;
    localparam int FLAG_CAPS   = 6;

    typedef logic [6:0]  flags_t;
    typedef logic [15:0] key_word_t;

    // Translator state carried from one transaction to the next.
    typedef struct packed {
        logic   prefix;
        flags_t flags;
    } sctk_state_t;

    // One result transaction.
    typedef struct packed {
        logic      key_valid;
        key_word_t key_word;
        flags_t    flags;
    } sctk_result_t;

    // Key ROM row: {plain, shift, ctrl, alt}.
    function automatic logic [63:0] key_rom_row(input logic [6:0] k);
        logic [63:0] row;
        case (k)
            7'h01: row = 64'h011B_011B_011B_0100;
            7'h02: row = 64'h0231_0221_0000_7800;
            7'h03: row = 64'h0332_0340_0300_7900;
            7'h04: row = 64'h0433_0423_0000_7A00;
            7'h05: row = 64'h0534_0524_0000_7B00;
            7'h06: row = 64'h0635_0625_0000_7C00;
            7'h07: row = 64'h0736_075E_071E_7D00;
            7'h08: row = 64'h0837_0826_0000_7E00;
            7'h09: row = 64'h0938_092A_0000_7F00;
            7'h0A: row = 64'h0A39_0A28_0000_8000;
            7'h0B: row = 64'h0B30_0B29_0000_8100;
            7'h0C: row = 64'h0C2D_0C5F_0C1F_8200;
            7'h0D: row = 64'h0D3D_0D2B_0000_8300;
            7'h0E: row = 64'h0E08_0E08_0E7F_0E00;
            7'h0F: row = 64'h0F09_0F00_9400_A500;
            7'h10: row = 64'h1071_1051_1011_1000;
            7'h11: row = 64'h1177_1157_1117_1100;
            7'h12: row = 64'h1265_1245_1205_1200;
            7'h13: row = 64'h1372_1352_1312_1300;
            7'h14: row = 64'h1474_1454_1414_1400;
            7'h15: row = 64'h1579_1559_1519_1500;
            7'h16: row = 64'h1675_1655_1615_1600;
            7'h17: row = 64'h1769_1749_1709_1700;
            7'h18: row = 64'h186F_184F_180F_1800;
            7'h19: row = 64'h1970_1950_1910_1900;
            7'h1A: row = 64'h1A5B_1A7B_1A1B_1A00;
            7'h1B: row = 64'h1B5D_1B7D_1B1D_1B00;
            7'h1C: row = 64'h1C0D_1C0D_1C0A_1C00;
            7'h1E: row = 64'h1E61_1E41_1E01_1E00;
            7'h1F: row = 64'h1F73_1F53_1F13_1F00;
            7'h20: row = 64'h2064_2044_2004_2000;
            7'h21: row = 64'h2166_2146_2106_2100;
            7'h22: row = 64'h2267_2247_2207_2200;
            7'h23: row = 64'h2368_2348_2308_2300;
            7'h24: row = 64'h246A_244A_240A_2400;
            7'h25: row = 64'h256B_254B_250B_2500;
            7'h26: row = 64'h266C_264C_260C_2600;
            7'h27: row = 64'h273B_273A_0000_2700;
            7'h28: row = 64'h2827_2822_0000_2800;
            7'h29: row = 64'h2960_297E_0000_2900;
            7'h2B: row = 64'h2B5C_2B7C_2B1C_2B00;
            7'h2C: row = 64'h2C7A_2C5A_2C1A_2C00;
            7'h2D: row = 64'h2D78_2D58_2D18_2D00;
            7'h2E: row = 64'h2E63_2E43_2E03_2E00;
            7'h2F: row = 64'h2F76_2F56_2F16_2F00;
            7'h30: row = 64'h3062_3042_3002_3000;
            7'h31: row = 64'h316E_314E_310E_3100;
            7'h32: row = 64'h326D_324D_320D_3200;
            7'h33: row = 64'h332C_333C_0000_3300;
            7'h34: row = 64'h342E_343E_0000_3400;
            7'h35: row = 64'h352F_353F_0000_3500;
            7'h37: row = 64'h372A_372A_9600_3700;
            7'h39: row = 64'h3920_3920_3920_3920;
            7'h3B: row = 64'h3B00_5400_5E00_6800;
            7'h3C: row = 64'h3C00_5500_5F00_6900;
            7'h3D: row = 64'h3D00_5600_6000_6A00;
            7'h3E: row = 64'h3E00_5700_6100_6B00;
            7'h3F: row = 64'h3F00_5800_6200_6C00;
            7'h40: row = 64'h4000_5900_6300_6D00;
            7'h41: row = 64'h4100_5A00_6400_6E00;
            7'h42: row = 64'h4200_5B00_6500_6F00;
            7'h43: row = 64'h4300_5C00_6600_7000;
            7'h44: row = 64'h4400_5D00_6700_7100;
            7'h47: row = 64'h4700_4737_7700_0000;
            7'h48: row = 64'h4800_4838_8D00_0000;
            7'h49: row = 64'h4900_4939_8400_0000;
            7'h4A: row = 64'h4A2D_4A2D_8E00_4A00;
            7'h4B: row = 64'h4B00_4B34_7300_0000;
            7'h4C: row = 64'h4CF0_4C35_8F00_0000;
            7'h4D: row = 64'h4D00_4D36_7400_0000;
            7'h4E: row = 64'h4E2B_4E2B_9000_4E00;
            7'h4F: row = 64'h4F00_4F31_7500_0000;
            7'h50: row = 64'h5000_5032_9100_0000;
            7'h51: row = 64'h5100_5133_7600_0000;
            7'h52: row = 64'h5200_5230_9200_0000;
            7'h53: row = 64'h5300_532E_9300_0000;
            7'h56: row = 64'h565C_567C_0000_0000;
            7'h57: row = 64'h8500_8700_8900_8B00;
            7'h58: row = 64'h8600_8800_8A00_8C00;
            default: row = 64'h0;
        endcase
        return row;
    endfunction

    // Enhanced Alt codes for the grey (prefixed) keys.
    function automatic key_word_t grey_alt_word(input logic [6:0] k);
        key_word_t w;
        case (k)
            7'h47: w = 16'h9700;
            7'h48: w = 16'h9800;
            7'h49: w = 16'h9900;
            7'h4B: w = 16'h9B00;
            7'h4D: w = 16'h9D00;
            7'h4F: w = 16'h9F00;
            7'h50: w = 16'hA000;
            7'h51: w = 16'hA100;
            7'h52: w = 16'hA200;
            7'h53: w = 16'hA300;
            7'h1C: w = 16'hA600;
            7'h35: w = 16'hA400;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/scancode_to_keycode_translator.sv
// Scancode set 1 to BIOS key word translator.
// Input channel: scan_valid / scan_stall carry one scancode byte per
// transaction in scan_byte. A byte is taken at a rising edge where
// scan_valid is high and scan_stall is low.
// Result channel: result_valid / result_stall carry one transaction per
// input byte: key_valid, key_word (scan code high, ASCII low) and the
// modifier_flags after that byte was applied.
// The byte lands in the input register at the accepting edge and its
// result moves to the result register once that register is free or being
// emptied; result_valid then shows it. Throughput is one byte per cycle
// while the receiver does not stall, set by the single translation pass.
// Reset clears the prefix flag, all modifier and lock flags, and both valid
// bits. When the receiver stalls, the result register holds its
// transaction; the input register keeps one more byte, and scan_stall rises
// only while both registers are full and the receiver still stalls.
`timescale 1ns / 1ps
`default_nettype none

module scancode_to_keycode_translator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        scan_valid,
    output logic             scan_stall,
    input  wire logic [7:0]  scan_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             key_valid,
    output logic [15:0]      key_word,
    output logic [6:0]       modifier_flags
);

    // Input register.
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;

    // Translator state, updated when the held byte moves to the result.
    sctk_pkg::sctk_state_t  state_reg;
    sctk_pkg::sctk_state_t  state_next;

    // Result register.
    logic                   result_valid_reg;
    sctk_pkg::sctk_result_t result_reg;
    sctk_pkg::sctk_result_t result_next;

    logic                   advance;
    logic                   scan_take;

    // The held byte moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign advance    = in_valid_reg && !(result_valid_reg && result_stall);
    assign scan_stall = in_valid_reg && result_valid_reg && result_stall;
    assign scan_take  = scan_valid && !scan_stall;

    sctk_decode u_decode (
        .scan_byte (in_byte_reg),
        .cur_state (state_reg),
        .nxt_state (state_next),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            state_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (scan_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg        <= state_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (scan_take)
        begin
            in_byte_reg <= scan_byte;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign key_valid      = result_reg.key_valid;
    assign key_word       = result_reg.key_word;
    assign modifier_flags = result_reg.flags;

    // A shown result flags a key exactly when its word is nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (key_valid == (key_word != 16'h0000)))
    else $error("key_valid does not match key_word");

    // An extended prefix byte arms the prefix once it is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_byte_reg == sctk_pkg::SC_PREFIX_E0)) |=> state_reg.prefix)
    else $error("prefix not armed after E0");

    // The flags shown with a fresh result are the state kept for the next byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_valid_reg && (modifier_flags == state_reg.flags)))
    else $error("result flags differ from kept state");

    // Upstream is only held off while a byte waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_stall |-> (in_valid_reg && !advance))
    else $error("stall without a waiting byte");

endmodule

`default_nettype wire

FILE: rtl/sctk_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// Combinational translation of one scancode byte against the current state.
module sctk_decode (
    input  wire logic [7:0]           scan_byte,
    input  wire sctk_pkg::sctk_state_t cur_state,
    output sctk_pkg::sctk_state_t      nxt_state,
    output sctk_pkg::sctk_result_t     result
);

    logic                 brk;
    logic [6:0]           k;
    logic                 ext;
    logic                 done;
    sctk_pkg::flags_t     f;
    logic [63:0]          row;
    logic                 sh;
    logic                 letter;
    logic                 keypad;
    sctk_pkg::key_word_t  word;
    logic [7:0]           grey_lo;

    assign brk = scan_byte[7];
    assign k   = scan_byte[6:0];
    assign ext = cur_state.prefix;

    always_comb
    begin
        f    = cur_state.flags;
        done = 1'b0;
        nxt_state.prefix = 1'b0;
        if (scan_byte == sctk_pkg::SC_PREFIX_E0)
        begin
            nxt_state.prefix = 1'b1;
            done = 1'b1;
        end
        else if (scan_byte == sctk_pkg::SC_PREFIX_E1)
        begin
            done = 1'b1;
        end
        else
        begin
            case (k)
                sctk_pkg::KEY_LSHIFT:
                begin
                    // The grey-key fake shift leaves the flags alone.
                    if (!ext)
                    begin
                        f[sctk_pkg::FLAG_LSHIFT] = !brk;
                    end
                    done = 1'b1;
                end
                sctk_pkg::KEY_RSHIFT:
                begin
                    f[sctk_pkg::FLAG_RSHIFT] = !brk;
                    done = 1'b1;
                end
                sctk_pkg::KEY_CTRL:
                begin
                    f[sctk_pkg::FLAG_CTRL] = !brk;
                    done = 1'b1;
                end
                sctk_pkg::KEY_ALT:
                begin
                    f[sctk_pkg::FLAG_ALT] = !brk;
                    done = 1'b1;
                end
                sctk_pkg::KEY_CAPS:
                begin
                    if (!brk)
                    begin
                        f[sctk_pkg::FLAG_CAPS] = !f[sctk_pkg::FLAG_CAPS];
                    end
                    done = 1'b1;
                end
                sctk_pkg::KEY_NUM:
                begin
                    if (!brk)
                    begin
                        f[sctk_pkg::FLAG_NUM] = !f[sctk_pkg::FLAG_NUM];
                    end
                    done = 1'b1;
                end
                sctk_pkg::KEY_SCROLL:
                begin
                    if (!brk)
                    begin
                        f[sctk_pkg::FLAG_SCROLL] = !f[sctk_pkg::FLAG_SCROLL];
                    end
                    done = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        nxt_state.flags = f;
    end

    assign row    = sctk_pkg::key_rom_row(k);
    assign letter = row[55:48] inside {[8'h61:8'h7A]};
    assign keypad = k inside {[sctk_pkg::KP_FIRST:sctk_pkg::KP_LAST]};

    always_comb
    begin
        sh = f[sctk_pkg::FLAG_LSHIFT] | f[sctk_pkg::FLAG_RSHIFT];
        if (f[sctk_pkg::FLAG_CAPS] && letter)
        begin
            sh = !sh;
        end
        if (f[sctk_pkg::FLAG_NUM] && keypad)
        begin
            sh = !sh;
        end
    end

    always_comb
    begin
        if (k == sctk_pkg::KEY_ENTER)
        begin
            grey_lo = sctk_pkg::ASCII_CR;
        end
        else if (k == sctk_pkg::KEY_SLASH)
        begin
            grey_lo = sctk_pkg::ASCII_SLASH;
        end
        else
        begin
            grey_lo = 8'h00;
        end
    end

    always_comb
    begin
        word = 16'h0000;
        if (!done && !brk && (k != 7'h00) && (k <= sctk_pkg::ROM_TOP))
        begin
            if (ext)
            begin
                if (f[sctk_pkg::FLAG_ALT])
                begin
                    word = sctk_pkg::grey_alt_word(k);
                end
                else if (f[sctk_pkg::FLAG_CTRL])
                begin
                    word = row[31:16];
                end
                else
                begin
                    word = {1'b0, k, grey_lo};
                end
            end
            else if (f[sctk_pkg::FLAG_ALT])
            begin
                word = row[15:0];
            end
            else if (f[sctk_pkg::FLAG_CTRL])
            begin
                word = row[31:16];
            end
            else if (sh)
            begin
                word = row[47:32];
            end
            else
            begin
                word = row[63:48];
            end
        end
    end

    assign result.key_valid = (word != 16'h0000);
    assign result.key_word  = word;
    assign result.flags     = f;

endmodule

`default_nettype wire

FILE: dv/tb_scancode_to_keycode_translator.sv
`timescale 1ns / 1ps

module tb_scancode_to_keycode_translator;

    import sctk_pkg::*;

    // Clock, reset and run length.
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 4;
    localparam int MAX_REPORTED   = 10;

    // Make codes used by the directed part and the scoreboard that the package does not name.
    localparam logic [6:0] KEY_A          = 7'h1E;
    localparam logic [6:0] KEY_C          = 7'h2E;
    localparam logic [6:0] KEY_LEFT       = 7'h4B;
    localparam logic [6:0] KEY_KP_MINUS   = 7'h4A;
    localparam logic [6:0] KEY_KP_CENTER  = 7'h4C;
    localparam logic [6:0] KEY_KP_PLUS    = 7'h4E;

    // Grey keys pressed with Alt map to the keypad code moved up by a fixed
    // offset; Enter and the slash key have codes of their own.
    localparam logic [7:0] GREY_ALT_OFFSET = 8'h50;
    localparam key_word_t  GREY_ALT_ENTER  = 16'hA600;
    localparam key_word_t  GREY_ALT_SLASH  = 16'hA400;

    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

    typedef enum int {COL_PLAIN, COL_SHIFT, COL_CTRL, COL_ALT} rom_col_e;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

    // Key words per make code, one row each, columns plain, shift, ctrl and
    // alt from the most significant end. A zero word means no key.
    localparam bit [0:88][63:0] KEY_TABLE = {
        64'h0,                   64'h011B_011B_011B_0100, 64'h0231_0221_0000_7800,
        64'h0332_0340_0300_7900, 64'h0433_0423_0000_7A00, 64'h0534_0524_0000_7B00,
        64'h0635_0625_0000_7C00, 64'h0736_075E_071E_7D00, 64'h0837_0826_0000_7E00,
        64'h0938_092A_0000_7F00, 64'h0A39_0A28_0000_8000, 64'h0B30_0B29_0000_8100,
        64'h0C2D_0C5F_0C1F_8200, 64'h0D3D_0D2B_0000_8300, 64'h0E08_0E08_0E7F_0E00,
        64'h0F09_0F00_9400_A500, 64'h1071_1051_1011_1000, 64'h1177_1157_1117_1100,
        64'h1265_1245_1205_1200, 64'h1372_1352_1312_1300, 64'h1474_1454_1414_1400,
        64'h1579_1559_1519_1500, 64'h1675_1655_1615_1600, 64'h1769_1749_1709_1700,
        64'h186F_184F_180F_1800, 64'h1970_1950_1910_1900, 64'h1A5B_1A7B_1A1B_1A00,
        64'h1B5D_1B7D_1B1D_1B00, 64'h1C0D_1C0D_1C0A_1C00, 64'h0,
        64'h1E61_1E41_1E01_1E00, 64'h1F73_1F53_1F13_1F00, 64'h2064_2044_2004_2000,
        64'h2166_2146_2106_2100, 64'h2267_2247_2207_2200, 64'h2368_2348_2308_2300,
        64'h246A_244A_240A_2400, 64'h256B_254B_250B_2500, 64'h266C_264C_260C_2600,
        64'h273B_273A_0000_2700, 64'h2827_2822_0000_2800, 64'h2960_297E_0000_2900,
        64'h0,                   64'h2B5C_2B7C_2B1C_2B00, 64'h2C7A_2C5A_2C1A_2C00,
        64'h2D78_2D58_2D18_2D00, 64'h2E63_2E43_2E03_2E00, 64'h2F76_2F56_2F16_2F00,
        64'h3062_3042_3002_3000, 64'h316E_314E_310E_3100, 64'h326D_324D_320D_3200,
        64'h332C_333C_0000_3300, 64'h342E_343E_0000_3400, 64'h352F_353F_0000_3500,
        64'h0,                   64'h372A_372A_9600_3700, 64'h0,
        64'h3920_3920_3920_3920, 64'h0,                   64'h3B00_5400_5E00_6800,
        64'h3C00_5500_5F00_6900, 64'h3D00_5600_6000_6A00, 64'h3E00_5700_6100_6B00,
        64'h3F00_5800_6200_6C00, 64'h4000_5900_6300_6D00, 64'h4100_5A00_6400_6E00,
        64'h4200_5B00_6500_6F00, 64'h4300_5C00_6600_7000, 64'h4400_5D00_6700_7100,
        64'h0,                   64'h0,                   64'h4700_4737_7700_0000,
        64'h4800_4838_8D00_0000, 64'h4900_4939_8400_0000, 64'h4A2D_4A2D_8E00_4A00,
        64'h4B00_4B34_7300_0000, 64'h4CF0_4C35_8F00_0000, 64'h4D00_4D36_7400_0000,
        64'h4E2B_4E2B_9000_4E00, 64'h4F00_4F31_7500_0000, 64'h5000_5032_9100_0000,
        64'h5100_5133_7600_0000, 64'h5200_5230_9200_0000, 64'h5300_532E_9300_0000,
        64'h0,                   64'h0,                   64'h565C_567C_0000_0000,
        64'h8500_8700_8900_8B00, 64'h8600_8800_8A00_8C00
    };

    // The scoreboard keeps its own copy of the prefix flag and the modifier
    // and lock flags, works out the key word for every accepted scancode byte
    // and holds those expectations until the matching result arrives.
    class key_scoreboard;
        logic         prefix_armed;
        flags_t       flags;
        sctk_result_t expected_q[$];
        int           mismatches;
        int           results_checked;
        int           keys_seen;

        function new();
            prefix_armed    = 1'b0;
            flags           = '0;
            mismatches      = 0;
            results_checked = 0;
            keys_seen       = 0;
        endfunction

        function key_word_t rom_word(logic [6:0] code, rom_col_e col);
            return KEY_TABLE[code][(3 - int'(col)) * 16 +: 16];
        endfunction

        function void note_scan(logic [7:0] scan);
            logic         brk;
            logic [6:0]   code;
            logic         ext;
            logic         handled;
            logic         shifted;
            key_word_t    word;
            key_word_t    plain_word;
            sctk_result_t want;
            brk     = scan[7];
            code    = scan[6:0];
            ext     = prefix_armed;
            handled = 1'b1;
            word    = '0;

            if (scan == SC_PREFIX_E0) begin
                prefix_armed = 1'b1;
            end else if (scan == SC_PREFIX_E1) begin
                prefix_armed = 1'b0;
            end else begin
                prefix_armed = 1'b0;
                case (code)
                    KEY_LSHIFT: if (!ext) flags[FLAG_LSHIFT] = !brk;
                    KEY_RSHIFT: flags[FLAG_RSHIFT] = !brk;
                    KEY_CTRL:   flags[FLAG_CTRL] = !brk;
                    KEY_ALT:    flags[FLAG_ALT] = !brk;
                    KEY_CAPS:   if (!brk) flags[FLAG_CAPS] = !flags[FLAG_CAPS];
                    KEY_NUM:    if (!brk) flags[FLAG_NUM] = !flags[FLAG_NUM];
                    KEY_SCROLL: if (!brk) flags[FLAG_SCROLL] = !flags[FLAG_SCROLL];
                    default:    handled = 1'b0;
                endcase
            end

            if (!handled && !brk && code != '0 && code <= ROM_TOP) begin
                if (ext) begin
                    if (flags[FLAG_ALT]) begin
                        if (code == KEY_ENTER)
                            word = GREY_ALT_ENTER;
                        else if (code == KEY_SLASH)
                            word = GREY_ALT_SLASH;
                        else if (code >= KP_FIRST && code <= KP_LAST &&
                                 code != KEY_KP_MINUS && code != KEY_KP_CENTER &&
                                 code != KEY_KP_PLUS)
                            word = {{1'b0, code} + GREY_ALT_OFFSET, 8'h00};
                    end else if (flags[FLAG_CTRL]) begin
                        word = rom_word(code, COL_CTRL);
                    end else begin
                        word = {1'b0, code,
                                (code == KEY_ENTER) ? ASCII_CR :
                                (code == KEY_SLASH) ? ASCII_SLASH : 8'h00};
                    end
                end else if (flags[FLAG_ALT]) begin
                    word = rom_word(code, COL_ALT);
                end else if (flags[FLAG_CTRL]) begin
                    word = rom_word(code, COL_CTRL);
                end else begin
                    plain_word = rom_word(code, COL_PLAIN);
                    shifted = flags[FLAG_LSHIFT] | flags[FLAG_RSHIFT];
                    if (flags[FLAG_CAPS] && plain_word[7:0] >= ASCII_LOWER_A &&
                        plain_word[7:0] <= ASCII_LOWER_Z)
                        shifted = !shifted;
                    if (flags[FLAG_NUM] && code >= KP_FIRST && code <= KP_LAST)
                        shifted = !shifted;
                    word = rom_word(code, shifted ? COL_SHIFT : COL_PLAIN);
                end
            end

            want.key_valid = (word != '0);
            want.key_word  = word;
            want.flags     = flags;
            expected_q.push_back(want);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("mismatch %0d at %0t: %s", mismatches, $realtime, what);
        endfunction

        function void check_result(logic kv, key_word_t kw, flags_t mf);
            sctk_result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with no byte pending: valid=%0b word=%04h flags=%02h",
                                 kv, kw, mf));
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (kv === 1'b1)
                keys_seen++;
            if (kv !== want.key_valid || kw !== want.key_word || mf !== want.flags)
                report($sformatf({"expected valid=%0b word=%04h flags=%02h, ",
                                  "got valid=%0b word=%04h flags=%02h"},
                                 want.key_valid, want.key_word, want.flags, kv, kw, mf));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       scan_valid = 1'b0;
    logic       scan_stall;
    logic [7:0] scan_byte = 8'h00;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       key_valid;
    key_word_t  key_word;
    flags_t     modifier_flags;

    key_scoreboard sb = new();

    // The whole stimulus is built before reset is released, then streamed.
    logic [7:0] scan_stream[$];

    stall_mode_e stall_mode = STALL_NONE;
    int          stall_cycles_left = 0;
    int          quiet_cycles = 0;

    scancode_to_keycode_translator uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .scan_valid     (scan_valid),
        .scan_stall     (scan_stall),
        .scan_byte      (scan_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .key_valid      (key_valid),
        .key_word       (key_word),
        .modifier_flags (modifier_flags)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Appends one keystroke byte to the stream, with the E0 prefix in front
    // of it when the grey form of the key is wanted.
    function automatic void queue_key(logic [6:0] code, logic grey, logic brk);
        if (grey)
            scan_stream.push_back(SC_PREFIX_E0);
        scan_stream.push_back({brk, code});
    endfunction

    // Presents one byte at the falling edge and holds it until a rising edge
    // sees the stall low. Valid stays high into the next call, so a burst of
    // bytes moves one transaction per cycle unless the block stalls.
    task automatic send_scan(input logic [7:0] scan);
        @(negedge clk);
        scan_valid <= 1'b1;
        scan_byte  <= scan;
        @(posedge clk);
        while (scan_stall)
            @(posedge clk);
        sb.note_scan(scan);
    endtask

    // Idles the input side for a number of cycles with junk on the byte lines.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        scan_valid <= 1'b0;
        scan_byte  <= 8'($urandom_range(0, 255));
        repeat (cycles)
            @(posedge clk);
    endtask

    // Holds the input side idle until every expected result has come back.
    task automatic wait_results_drained();
        @(negedge clk);
        scan_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // The receiver picks a stall behavior for a stretch of cycles: never,
    // now and then, most of the time, or a fixed two-in-five pattern. The
    // stretches with no stall let the block run at full rate.
    always @(negedge clk) begin
        if (stall_cycles_left == 0) begin
            stall_mode        = stall_mode_e'($urandom_range(0, 3));
            stall_cycles_left = $urandom_range(16, 96);
        end
        stall_cycles_left--;
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
            default:     result_stall <= ((stall_cycles_left % 5) < 2);
        endcase
    end

    // Every result transaction is checked against the oldest expectation.
    // Sampling happens at the rising edge, so the values seen are the ones
    // that were settled before the edge.
    always @(posedge clk) begin
        if (rst_n && result_valid === 1'b1 && !result_stall)
            sb.check_result(key_valid, key_word, modifier_flags);
    end

    // The watchdog ends the run when neither side has moved a transaction
    // for too long, which covers a hung block as well as lost results.
    always @(posedge clk) begin
        if ((scan_valid && scan_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.expected_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int         idx;
        int         burst_left;
        int         seq_kind;
        int         mods;
        int         directed_count;
        logic       grey;
        logic [6:0] code;

        // Directed part. It starts with the byte extremes and the codes just
        // inside and outside the table, then walks through shift, caps lock
        // on a letter, num lock on the keypad, the fake shift that follows
        // E0, grey Enter, a prefix cancelled by E1, a prefixed Ctrl with a
        // plain and a grey key, and finally Alt with a grey arrow key.
        scan_stream.push_back(8'h00);
        scan_stream.push_back(8'hFF);
        queue_key(ROM_TOP + 7'd1, 1'b0, 1'b0);
        queue_key(ROM_TOP, 1'b0, 1'b0);
        queue_key(KEY_LSHIFT, 1'b0, 1'b0);
        queue_key(KEY_A, 1'b0, 1'b0);
        queue_key(KEY_CAPS, 1'b0, 1'b0);
        queue_key(KEY_A, 1'b0, 1'b0);
        queue_key(KEY_LSHIFT, 1'b0, 1'b1);
        queue_key(KEY_NUM, 1'b0, 1'b0);
        queue_key(KP_FIRST, 1'b0, 1'b0);
        queue_key(KEY_LSHIFT, 1'b1, 1'b0);
        queue_key(KEY_ENTER, 1'b1, 1'b0);
        scan_stream.push_back(SC_PREFIX_E0);
        scan_stream.push_back(SC_PREFIX_E1);
        queue_key(KP_FIRST, 1'b0, 1'b0);
        queue_key(KEY_CTRL, 1'b1, 1'b0);
        queue_key(KEY_C, 1'b0, 1'b0);
        queue_key(KEY_ENTER, 1'b1, 1'b0);
        queue_key(KEY_ALT, 1'b0, 1'b0);
        queue_key(KEY_LEFT, 1'b1, 1'b0);
        directed_count = scan_stream.size();

        // Random part. Most of it is typing: some modifiers held, a plain or
        // grey key pressed one or more times and released, then the
        // modifiers released, though now and then they are left down. The
        // rest toggles the locks, sends raw bytes, or breaks up prefix
        // sequences in the ways a noisy link might.
        while (scan_stream.size() < directed_count + RANDOM_ITEMS) begin
            seq_kind = $urandom_range(0, 99);
            if (seq_kind < 60) begin
                mods = $urandom_range(0, 15) & $urandom_range(0, 15);
                if (mods[0]) queue_key(KEY_LSHIFT, 1'b0, 1'b0);
                if (mods[1]) queue_key(KEY_RSHIFT, 1'b0, 1'b0);
                if (mods[2]) queue_key(KEY_CTRL, 1'($urandom_range(0, 1)), 1'b0);
                if (mods[3]) queue_key(KEY_ALT, 1'($urandom_range(0, 1)), 1'b0);
                grey = ($urandom_range(0, 3) == 0);
                if (!grey)
                    code = 7'($urandom_range(1, ROM_TOP));
                else if ($urandom_range(0, 5) == 0)
                    code = KEY_ENTER;
                else if ($urandom_range(0, 4) == 0)
                    code = KEY_SLASH;
                else
                    code = 7'($urandom_range(KP_FIRST, KP_LAST));
                repeat ($urandom_range(1, 3))
                    queue_key(code, grey, 1'b0);
                queue_key(code, grey, 1'b1);
                if ($urandom_range(0, 4) != 0) begin
                    if (mods[0]) queue_key(KEY_LSHIFT, 1'b0, 1'b1);
                    if (mods[1]) queue_key(KEY_RSHIFT, 1'b0, 1'b1);
                    if (mods[2]) queue_key(KEY_CTRL, 1'($urandom_range(0, 1)), 1'b1);
                    if (mods[3]) queue_key(KEY_ALT, 1'($urandom_range(0, 1)), 1'b1);
                end
            end else if (seq_kind < 70) begin
                case ($urandom_range(0, 2))
                    0:       code = KEY_CAPS;
                    1:       code = KEY_NUM;
                    default: code = KEY_SCROLL;
                endcase
                queue_key(code, 1'b0, 1'b0);
                queue_key(code, 1'b0, 1'b1);
            end else if (seq_kind < 85) begin
                scan_stream.push_back(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        scan_stream.push_back(SC_PREFIX_E0);
                        scan_stream.push_back(8'($urandom_range(0, 255)));
                    end
                    1: begin
                        scan_stream.push_back(SC_PREFIX_E1);
                        scan_stream.push_back(8'($urandom_range(0, 255)));
                    end
                    2: begin
                        scan_stream.push_back(SC_PREFIX_E0);
                        queue_key(7'($urandom_range(1, ROM_TOP)), 1'b1, 1'b0);
                    end
                    default: begin
                        queue_key(KEY_LSHIFT, 1'b1, 1'($urandom_range(0, 1)));
                        queue_key(7'($urandom_range(1, ROM_TOP)), 1'b0, 1'b0);
                    end
                endcase
            end
        end

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Bytes go out in bursts of random length. Most bursts start after a
        // short gap and some follow the previous one directly. Twice the
        // sender stops until the block has returned every result: once after
        // the directed part and once halfway through the random part.
        burst_left = 0;
        for (idx = 0; idx < scan_stream.size(); idx++) begin
            if (idx == directed_count || idx == directed_count + RANDOM_ITEMS / 2)
                wait_results_drained();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 12));
            end
            send_scan(scan_stream[idx]);
            burst_left--;
        end

        // Let the last results come back, then watch a few more cycles for
        // anything the block should not have sent.
        wait_results_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Covered %0d scancode bytes: %0d directed, the rest typing with modifiers,",
                 scan_stream.size(), directed_count);
        $display("lock toggles, raw bytes and broken prefixes; %0d results, %0d keys, %0d bad.",
                 sb.results_checked, sb.keys_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
